/* src/lwg_pkg.sv */
// Shared types and constants for the LCD window and glyph writer.
// No dependencies.
package lwg_pkg;

  localparam int MAX_GLYPH_WIDTH_DEF = 24;
  localparam int ROW_BITS_W          = 24;
  localparam int ROW_W               = 5;
  localparam int QUEUE_DEPTH         = 4;

  localparam logic [1:0] ACT_WINDOW = 2'd0;
  localparam logic [1:0] ACT_GLYPH  = 2'd1;
  localparam logic [1:0] ACT_PIXEL  = 2'd2;

  localparam logic [15:0] CMD_COL_ADDR  = 16'h002A;
  localparam logic [15:0] CMD_ROW_ADDR  = 16'h002B;
  localparam logic [15:0] CMD_MEM_WRITE = 16'h002C;

  typedef enum logic [1:0] {
    KIND_WINDOW = 2'd0,
    KIND_GLYPH  = 2'd1,
    KIND_PIXEL  = 2'd2
  } lwg_kind_t;

  // Window: w0 = x, w1 = x end, w2 = y, w3 = y end.
  // Glyph: w0 = fg, w1 = bg, bits, count. Pixel: w0 = packed pixel.
  typedef struct packed {
    lwg_kind_t               kind;
    logic [ROW_W-1:0]        count;
    logic [15:0]             w0;
    logic [15:0]             w1;
    logic [15:0]             w2;
    logic [15:0]             w3;
    logic [ROW_BITS_W-1:0]   bits;
  } lwg_entry_t;

endpackage

/* src/lwg_front.sv */
// Front end: accepts drawing requests, classifies them and builds queue entries.
// Depends on lwg_pkg. Holds the glyph row width.
module lwg_front import lwg_pkg::*; #(
  parameter int MAX_GLYPH_WIDTH = MAX_GLYPH_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            action,
  input  logic [15:0]           x,
  input  logic [15:0]           y,
  input  logic [15:0]           width,
  input  logic [15:0]           height,
  input  logic [15:0]           fg_color,
  input  logic [15:0]           bg_color,
  input  logic [ROW_BITS_W-1:0] row_bits,
  input  logic [7:0]            pixel_low,
  input  logic [7:0]            pixel_high,
  input  logic                  q_full,
  output logic                  push,
  output lwg_entry_t            push_entry
);

  localparam int CAP = (MAX_GLYPH_WIDTH < ROW_BITS_W) ? MAX_GLYPH_WIDTH : ROW_BITS_W;

  logic [ROW_W-1:0] row_width;
  logic [ROW_W-1:0] row_width_next;
  logic             take;

  assign in_stall = q_full;
  assign take     = in_valid && !q_full;

  always_comb begin
    row_width_next = row_width;
    push           = 1'b0;
    push_entry     = '0;
    push_entry.kind  = KIND_PIXEL;
    push_entry.count = row_width;
    push_entry.bits  = row_bits;
    unique case (action)
      ACT_WINDOW: begin
        push            = take;
        push_entry.kind = KIND_WINDOW;
        push_entry.w0   = x;
        push_entry.w1   = x + width - 16'd1;
        push_entry.w2   = y;
        push_entry.w3   = y + height - 16'd1;
        if (take) begin
          row_width_next = (width < 16'(CAP)) ? width[ROW_W-1:0] : ROW_W'(CAP);
        end
      end
      ACT_GLYPH: begin
        // drop rows of a zero-width window: they make no writes
        push            = take && (row_width != '0);
        push_entry.kind = KIND_GLYPH;
        push_entry.w0   = fg_color;
        push_entry.w1   = bg_color;
      end
      ACT_PIXEL: begin
        push            = take;
        push_entry.kind = KIND_PIXEL;
        push_entry.w0   = {pixel_high, pixel_low};
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_width <= ROW_W'(16);
    end else begin
      row_width <= row_width_next;
    end
  end

endmodule

/* src/lwg_queue.sv */
// Short FIFO of classified requests between front and back ends.
// Depends on lwg_pkg.
module lwg_queue import lwg_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  lwg_entry_t push_entry,
  output logic       full,
  input  logic       pop,
  output logic       head_valid,
  output lwg_entry_t head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  lwg_entry_t     mem [DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;

  assign full       = (count == CW'(DEPTH));
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

/* src/lwg_back.sv */
// Back end: expands the queue head into bus writes, one per cycle while not
// stalled, into an output register. Depends on lwg_pkg.
module lwg_back import lwg_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        head_valid,
  input  lwg_entry_t  head,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        is_data,
  output logic [15:0] bus_word,
  output logic        last
);

  logic [ROW_W-1:0] step;
  logic [ROW_W-1:0] pos;
  logic             advance;
  logic             fire;
  logic             d_next;
  logic [15:0]      word_next;
  logic             last_next;

  assign advance = !out_valid || !out_stall;
  assign fire    = head_valid && advance;
  assign pop     = fire && last_next;
  assign pos     = head.count - ROW_W'(1) - step;

  always_comb begin
    d_next    = 1'b1;
    word_next = head.w0;
    last_next = 1'b1;
    unique case (head.kind)
      KIND_WINDOW: begin
        last_next = 1'b0;
        unique case (step)
          ROW_W'(0): begin d_next = 1'b0; word_next = CMD_COL_ADDR; end
          ROW_W'(1): word_next = {8'h00, head.w0[15:8]};
          ROW_W'(2): word_next = head.w0;
          ROW_W'(3): word_next = {8'h00, head.w1[15:8]};
          ROW_W'(4): word_next = head.w1;
          ROW_W'(5): begin d_next = 1'b0; word_next = CMD_ROW_ADDR; end
          ROW_W'(6): word_next = {8'h00, head.w2[15:8]};
          ROW_W'(7): word_next = head.w2;
          ROW_W'(8): word_next = {8'h00, head.w3[15:8]};
          ROW_W'(9): word_next = head.w3;
          default: begin
            d_next    = 1'b0;
            word_next = CMD_MEM_WRITE;
            last_next = 1'b1;
          end
        endcase
      end
      KIND_GLYPH: begin
        word_next = head.bits[pos] ? head.w0 : head.w1;
        last_next = (step == head.count - ROW_W'(1));
      end
      KIND_PIXEL: begin
        word_next = head.w0;
      end
      default: begin
        word_next = head.w0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      step      <= '0;
    end else begin
      if (advance) begin
        out_valid <= fire;
      end
      if (fire) begin
        step <= last_next ? '0 : step + ROW_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      is_data  <= d_next;
      bus_word <= word_next;
      last     <= last_next;
    end
  end

endmodule

/* src/lcd_window_glyph_writer.sv */
// LCD window and glyph writer, top level.
// Depends on lwg_pkg, lwg_front, lwg_queue, lwg_back.
//
// Input channel (in_valid / in_stall) takes one drawing request per beat:
// open window, glyph row or image pixel. Output channel (out_valid /
// out_stall) gives one 16-bit bus write per beat with its data/command flag
// and a last flag on the final write of each request.
//
// An open window makes 11 writes, a glyph row makes one write per pixel of
// the current row width (0 to 24), an image pixel makes one. The back end
// emits one write per cycle while out_stall is low, and consecutive requests
// follow without gaps. A request passes through its queue entry and then
// the output register before its first write shows. A four-entry queue
// lets the front keep taking requests while the back works; in_stall
// rises only when that queue is full. Undefined actions and glyph rows
// under a zero width are taken and dropped.
//
// Reset empties the queue and output register and sets the row width to 16.
// While out_stall is high over a valid write, that write holds and the back end waits.
module lcd_window_glyph_writer import lwg_pkg::*; #(
  parameter int MAX_GLYPH_WIDTH = MAX_GLYPH_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            action,
  input  logic [15:0]           x,
  input  logic [15:0]           y,
  input  logic [15:0]           width,
  input  logic [15:0]           height,
  input  logic [15:0]           fg_color,
  input  logic [15:0]           bg_color,
  input  logic [ROW_BITS_W-1:0] row_bits,
  input  logic [7:0]            pixel_low,
  input  logic [7:0]            pixel_high,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  is_data,
  output logic [15:0]           bus_word,
  output logic                  last
);

  logic       q_full;
  logic       push;
  lwg_entry_t push_entry;
  logic       pop;
  logic       head_valid;
  lwg_entry_t head;

  lwg_front #(.MAX_GLYPH_WIDTH(MAX_GLYPH_WIDTH)) u_front (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .x(x), .y(y), .width(width), .height(height),
    .fg_color(fg_color), .bg_color(bg_color), .row_bits(row_bits),
    .pixel_low(pixel_low), .pixel_high(pixel_high),
    .q_full(q_full), .push(push), .push_entry(push_entry)
  );

  lwg_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk(clk), .rst(rst),
    .push(push), .push_entry(push_entry), .full(q_full),
    .pop(pop), .head_valid(head_valid), .head(head)
  );

  lwg_back u_back (
    .clk(clk), .rst(rst),
    .head_valid(head_valid), .head(head), .pop(pop),
    .out_valid(out_valid), .out_stall(out_stall),
    .is_data(is_data), .bus_word(bus_word), .last(last)
  );

endmodule

/* src/lwg_checker.sv */
// Port-level checks for the LCD window and glyph writer, bound to the top.
// Depends on lwg_pkg and lcd_window_glyph_writer.
module lwg_checker import lwg_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        is_data,
  input logic [15:0] bus_word,
  input logic        last
);

  // empty after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid && !in_stall)
    else $error("output or stall active right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(bus_word) && $stable(is_data)
      && $stable(last))
    else $error("stalled write changed");

  a_cmd_code: assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_data |-> bus_word == CMD_COL_ADDR || bus_word == CMD_ROW_ADDR
      || bus_word == CMD_MEM_WRITE)
    else $error("unknown command word");

  a_mem_write_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_data |-> last == (bus_word == CMD_MEM_WRITE))
    else $error("last flag wrong on command word");

endmodule

bind lcd_window_glyph_writer lwg_checker u_lwg_checker (
  .clk(clk), .rst(rst), .in_stall(in_stall), .out_valid(out_valid),
  .out_stall(out_stall), .is_data(is_data), .bus_word(bus_word), .last(last)
);

/* tb/lcd_window_glyph_writer_tb.sv */
// Testbench for lcd_window_glyph_writer: directed table, then random drawing requests,
// with every bus write checked against expected writes from the table or a local model.
// Depends on lwg_pkg and the lcd_window_glyph_writer RTL.
`timescale 1ns / 100ps

module lcd_window_glyph_writer_tb;
  import lwg_pkg::*;

  localparam logic [1:0] ACT_UNUSED  = 2'd3;
  localparam int GLYPH_CAP      = (MAX_GLYPH_WIDTH_DEF < ROW_BITS_W) ? MAX_GLYPH_WIDTH_DEF
                                                                      : ROW_BITS_W;
  localparam int PREDICT        = -1;
  localparam int RANDOM_ITEMS   = 430;
  localparam int PRESSURE_AT    = 60;
  localparam int CALM_AT        = 370;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 40;
  localparam int MAX_REPORTS    = 10;

  typedef struct {
    logic [1:0]            act;
    logic [15:0]           px;
    logic [15:0]           py;
    logic [15:0]           pw;
    logic [15:0]           ph;
    logic [15:0]           fg;
    logic [15:0]           bg;
    logic [ROW_BITS_W-1:0] bits;
    logic [7:0]            lo;
    logic [7:0]            hi;
  } draw_req_t;

  typedef struct packed {
    logic        data;
    logic [15:0] word;
    logic        fin;
  } bus_write_t;

  typedef struct {
    draw_req_t   req;
    int          n_typed;
    logic [15:0] typed_word;
  } dir_row_t;

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_stall;
  logic [1:0]            action;
  logic [15:0]           x;
  logic [15:0]           y;
  logic [15:0]           width;
  logic [15:0]           height;
  logic [15:0]           fg_color;
  logic [15:0]           bg_color;
  logic [ROW_BITS_W-1:0] row_bits;
  logic [7:0]            pixel_low;
  logic [7:0]            pixel_high;
  logic                  out_valid;
  logic                  out_stall;
  logic                  is_data;
  logic [15:0]           bus_word;
  logic                  last;

  bus_write_t       pending_writes[$];
  dir_row_t         directed_rows[$];
  logic [ROW_W-1:0] glyph_width;
  int               bad_writes;
  bit               hold_on;
  bit               calm;

  lcd_window_glyph_writer u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .action     (action),
    .x          (x),
    .y          (y),
    .width      (width),
    .height     (height),
    .fg_color   (fg_color),
    .bg_color   (bg_color),
    .row_bits   (row_bits),
    .pixel_low  (pixel_low),
    .pixel_high (pixel_high),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .is_data    (is_data),
    .bus_word   (bus_word),
    .last       (last)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // Address phase for one axis: command, start high byte, start, end high byte, end.
  task automatic push_axis(input logic [15:0] cmd, input logic [15:0] start,
                           input logic [15:0] size);
    logic [15:0] stop;
    stop = start + size - 16'd1;
    pending_writes.push_back('{1'b0, cmd, 1'b0});
    pending_writes.push_back('{1'b1, {8'h00, start[15:8]}, 1'b0});
    pending_writes.push_back('{1'b1, start, 1'b0});
    pending_writes.push_back('{1'b1, {8'h00, stop[15:8]}, 1'b0});
    pending_writes.push_back('{1'b1, stop, 1'b0});
  endtask

  task automatic predict_writes(input draw_req_t r);
    int n;
    n = glyph_width;
    case (r.act)
      ACT_WINDOW: begin
        push_axis(CMD_COL_ADDR, r.px, r.pw);
        push_axis(CMD_ROW_ADDR, r.py, r.ph);
        pending_writes.push_back('{1'b0, CMD_MEM_WRITE, 1'b1});
        glyph_width = (r.pw < GLYPH_CAP) ? r.pw[ROW_W-1:0] : ROW_W'(GLYPH_CAP);
      end
      ACT_GLYPH: begin
        for (int j = 0; j < n; j++) begin
          pending_writes.push_back('{1'b1, r.bits[n-1-j] ? r.fg : r.bg, j == n - 1});
        end
      end
      ACT_PIXEL: pending_writes.push_back('{1'b1, {r.hi, r.lo}, 1'b1});
      default: ;
    endcase
  endtask

  task automatic offer_request(input draw_req_t r, input int n_typed,
                               input logic [15:0] typed_word);
    if (!calm && !hold_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    action     <= r.act;
    x          <= r.px;
    y          <= r.py;
    width      <= r.pw;
    height     <= r.ph;
    fg_color   <= r.fg;
    bg_color   <= r.bg;
    row_bits   <= r.bits;
    pixel_low  <= r.lo;
    pixel_high <= r.hi;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (n_typed == PREDICT) begin
      predict_writes(r);
    end else begin
      for (int k = 0; k < n_typed; k++) begin
        pending_writes.push_back('{1'b1, typed_word, k == n_typed - 1});
      end
    end
  endtask

  function automatic void add_row(input logic [1:0] act, input logic [15:0] px,
                                  input logic [15:0] py, input logic [15:0] pw,
                                  input logic [15:0] ph, input logic [15:0] fg,
                                  input logic [15:0] bg, input logic [ROW_BITS_W-1:0] bits,
                                  input logic [7:0] lo, input logic [7:0] hi,
                                  input int n_typed, input logic [15:0] typed_word);
    dir_row_t row;
    row.req        = '{act, px, py, pw, ph, fg, bg, bits, lo, hi};
    row.n_typed    = n_typed;
    row.typed_word = typed_word;
    directed_rows.push_back(row);
  endfunction

  // Receiver: random stall bursts, one long hold-off on request, none near the end.
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_on) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        hold_on = 1'b0;
      end else if (!calm && !rst && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 11)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_writes.size() == 0) begin
        bad_writes++;
        if (bad_writes <= MAX_REPORTS)
          $display("%0t: unexpected bus write d=%0b w=%h l=%0b", $realtime,
                   is_data, bus_word, last);
      end else begin
        bus_write_t want;
        want = pending_writes.pop_front();
        if (is_data !== want.data || bus_word !== want.word || last !== want.fin) begin
          bad_writes++;
          if (bad_writes <= MAX_REPORTS)
            $display("%0t: bus write mismatch: got d=%0b w=%h l=%0b, want d=%0b w=%h l=%0b",
                     $realtime, is_data, bus_word, last, want.data, want.word, want.fin);
        end
      end
    end
  end

  initial begin
    draw_req_t r;
    int        productive;
    int        pick;
    bit        pressure_done;

    bad_writes    = 0;
    hold_on       = 1'b0;
    calm          = 1'b0;
    pressure_done = 1'b0;
    productive    = 0;
    glyph_width   = ROW_W'(16);
    rst        <= 1'b1;
    in_valid   <= 1'b0;
    action     <= ACT_WINDOW;
    x          <= '0;
    y          <= '0;
    width      <= '0;
    height     <= '0;
    fg_color   <= '0;
    bg_color   <= '0;
    row_bits   <= '0;
    pixel_low  <= '0;
    pixel_high <= '0;

    // Glyph rows at the reset width, pixel extremes, dropped action.
    add_row(ACT_GLYPH,  0, 0, 0, 0, 16'hF800, 16'h001F, 24'hFFFFFF, 0, 0, 16, 16'hF800);
    add_row(ACT_GLYPH,  0, 0, 0, 0, 16'h07E0, 16'hFFFF, 24'h000000, 0, 0, 16, 16'hFFFF);
    add_row(ACT_GLYPH,  0, 0, 0, 0, 16'h1234, 16'hABCD, 24'h5AA5C3, 0, 0, PREDICT, 0);
    add_row(ACT_PIXEL,  0, 0, 0, 0, 0, 0, 0, 8'h00, 8'h00, 1, 16'h0000);
    add_row(ACT_PIXEL,  0, 0, 0, 0, 0, 0, 0, 8'hFF, 8'hFF, 1, 16'hFFFF);
    add_row(ACT_PIXEL,  0, 0, 0, 0, 0, 0, 0, 8'h34, 8'h12, 1, 16'h1234);
    add_row(ACT_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
            24'hFFFFFF, 8'hFF, 8'hFF, 0, 0);
    // Zero width window: ends wrap, then glyph rows are dropped.
    add_row(ACT_WINDOW, 0, 0, 0, 0, 0, 0, 0, 0, 0, PREDICT, 0);
    add_row(ACT_GLYPH,  0, 0, 0, 0, 16'hFFFF, 16'h0000, 24'hFFFFFF, 0, 0, 0, 0);
    add_row(ACT_PIXEL,  0, 0, 0, 0, 0, 0, 0, 8'hA5, 8'h5A, 1, 16'h5AA5);
    // Largest window: width capped, full-width glyph rows.
    add_row(ACT_WINDOW, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 0, 0, 0, 0, PREDICT, 0);
    add_row(ACT_GLYPH,  0, 0, 0, 0, 16'hFFFF, 16'h0000, 24'hFFFFFF, 0, 0, 24, 16'hFFFF);
    add_row(ACT_GLYPH,  0, 0, 0, 0, 16'h0000, 16'hFFFF, 24'h000000, 0, 0, 24, 16'hFFFF);
    add_row(ACT_GLYPH,  0, 0, 0, 0, 16'h8001, 16'h7FFE, 24'h800001, 0, 0, PREDICT, 0);
    add_row(ACT_WINDOW, 16'h1234, 16'h5678, 16'd25, 16'd1, 0, 0, 0, 0, 0, PREDICT, 0);
    add_row(ACT_GLYPH,  0, 0, 0, 0, 16'h0F0F, 16'hF0F0, 24'h555555, 0, 0, PREDICT, 0);
    // One pixel wide window with a row end below its start.
    add_row(ACT_WINDOW, 16'hFFF0, 16'h0010, 16'd1, 16'd0, 0, 0, 0, 0, 0, PREDICT, 0);
    add_row(ACT_GLYPH,  0, 0, 0, 0, 16'hC0DE, 16'hBEEF, 24'h000001, 0, 0, 1, 16'hC0DE);
    add_row(ACT_GLYPH,  0, 0, 0, 0, 16'hC0DE, 16'hBEEF, 24'hFFFFFE, 0, 0, 1, 16'hBEEF);
    add_row(ACT_WINDOW, 16'h00FF, 16'hFF00, 16'd23, 16'hFFFF, 0, 0, 0, 0, 0, PREDICT, 0);
    add_row(ACT_GLYPH,  0, 0, 0, 0, 16'h6B4D, 16'h94B2, 24'h3C3C3C, 0, 0, PREDICT, 0);
    add_row(ACT_UNUSED, 16'h0001, 16'h8000, 16'd5, 16'd7, 16'h1111, 16'h2222,
            24'h0F0F0F, 8'h12, 8'h34, 0, 0);
    add_row(ACT_WINDOW, 16'h0100, 16'h0200, 16'd16, 16'd16, 0, 0, 0, 0, 0, PREDICT, 0);
    add_row(ACT_GLYPH,  0, 0, 0, 0, 16'hAAAA, 16'h5555, 24'h00A55A, 0, 0, PREDICT, 0);

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i])
      offer_request(directed_rows[i].req, directed_rows[i].n_typed,
                    directed_rows[i].typed_word);

    while (productive < RANDOM_ITEMS) begin
      pick   = $urandom_range(0, 99);
      r.px   = 16'($urandom);
      r.py   = 16'($urandom);
      r.pw   = 16'($urandom);
      r.ph   = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 40)) : 16'($urandom);
      r.fg   = 16'($urandom);
      r.bg   = 16'($urandom);
      r.bits = ROW_BITS_W'($urandom);
      r.lo   = 8'($urandom);
      r.hi   = 8'($urandom);
      if (pick < 20) begin
        r.act = ACT_WINDOW;
        // Keep most windows near glyph sizes so the width cap is crossed often.
        if ($urandom_range(0, 2) != 0) r.pw = 16'($urandom_range(0, 26));
      end else if (pick < 65) begin
        r.act = ACT_GLYPH;
        case ($urandom_range(0, 9))
          0: r.bits = '0;
          1: r.bits = '1;
          default: ;
        endcase
      end else if (pick < 92) begin
        r.act = ACT_PIXEL;
      end else begin
        r.act = ACT_UNUSED;
      end
      if (r.act != ACT_UNUSED && !(r.act == ACT_GLYPH && glyph_width == 0))
        productive++;
      if (productive == PRESSURE_AT && !pressure_done) begin
        pressure_done = 1'b1;
        hold_on       = 1'b1;
      end
      if (productive >= CALM_AT) calm = 1'b1;
      offer_request(r, PREDICT, 16'h0000);
    end
    in_valid <= 1'b0;

    while (pending_writes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (bad_writes == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
src/lwg_pkg.sv
src/lwg_front.sv
src/lwg_queue.sv
src/lwg_back.sv
src/lcd_window_glyph_writer.sv
src/lwg_checker.sv
tb/lcd_window_glyph_writer_tb.sv
